// ----- design/mcw_pkg.sv -----
// Shared types, constants and control structs for the multi-channel task watchdog.
package mcw_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int TICK_W     = 32;
  localparam int CFG_W      = 32;
  localparam int SLOT_W     = 4;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PADDR_W    = 3;

  localparam logic [CFG_W-1:0] SCAN_INTERVAL_RST = CFG_W'(1000);

  // Register index as seen in paddr[2]
  localparam logic REG_SCAN_INTERVAL = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_REGISTER   = 2'd1,
    OP_UNREGISTER = 2'd2,
    OP_KICK       = 2'd3
  } mcw_op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;      // take the request word into the datapath
    logic scan_start;  // stamp scan time, clear overdue mask, rewind index
    logic scan_rd;     // read slot tables at the scan index and advance
    logic pop;         // drop the lowest overdue slot
  } mcw_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_due;    // time since last scan has reached the check period
    logic scan_last;   // scan index sits on the final slot
    logic mask_any;    // at least one overdue slot still to report
    logic mask_single; // exactly one overdue slot left
  } mcw_sts_t;

endpackage

// ----- design/mcw_if.sv -----
// Valid/ready channel interfaces for request and response words.
interface mcw_req_if import mcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [SLOT_W-1:0] slot;
  logic [31:0]       delay_limit;

  modport source (output valid, operation, slot, delay_limit, input ready);
  modport sink   (input valid, operation, slot, delay_limit, output ready);
endinterface

interface mcw_rsp_if import mcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] expired_slot;
  logic              last;

  modport source (output valid, expired_slot, last, input ready);
  modport sink   (input valid, expired_slot, last, output ready);
endinterface

// ----- design/multi_channel_task_watchdog.sv -----
// Top level of the multi-channel task watchdog: controller, datapath and APB register port.
//
// One request word is handled at a time. Register, unregister and kick words
// are taken in the idle state; a tick passes through a check state, which
// returns to idle when no scan is due. A due scan runs through the scan,
// flush and emit states, and the response side may stall the reporting:
// the scan visits one slot per cycle through the single read port of the
// slot tables, and overdue slots are then reported lowest index first, the
// final one marked by last. The user must write the scan interval over APB
// at byte address 0 only while the block is idle; the block does not enforce it.
module multi_channel_task_watchdog import mcw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  mcw_req_if.sink             req,
  mcw_rsp_if.source           rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [CFG_W-1:0]    pwdata,
  output logic [CFG_W-1:0]    prdata,
  output logic                pready
);

  mcw_cmd_t cmd;
  mcw_sts_t sts;
  logic     cfg_wr;

  // Register write on the APB access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  mcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.operation),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (req.operation),
    .slot         (req.slot),
    .delay_limit  (req.delay_limit),
    .cfg_wr       (cfg_wr),
    .cfg_sel      (paddr[2]),
    .cfg_wdata    (pwdata),
    .cfg_rdata    (prdata),
    .expired_slot (rsp.expired_slot),
    .last         (rsp.last)
  );

endmodule

// ----- design/mcw_dp.sv -----
// Watchdog datapath: time base, slot tables, scan compare and overdue mask.
module mcw_dp import mcw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mcw_cmd_t           cmd,
  output mcw_sts_t           sts,
  input  logic [1:0]         operation,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [31:0]        delay_limit,
  input  logic               cfg_wr,
  input  logic               cfg_sel,
  input  logic [CFG_W-1:0]   cfg_wdata,
  output logic [CFG_W-1:0]   cfg_rdata,
  output logic [SLOT_W-1:0]  expired_slot,
  output logic               last
);

  logic [CFG_W-1:0]      scan_interval;
  logic [TICK_W-1:0]     time_now;
  logic [TICK_W-1:0]     last_scan_time;
  logic [NUM_SLOTS-1:0]  armed;
  logic [TICK_W-1:0]     kick_mem  [NUM_SLOTS];
  logic [TICK_W-1:0]     delay_mem [NUM_SLOTS];
  logic [TICK_W-1:0]     kick_q;
  logic [TICK_W-1:0]     delay_q;
  logic [SLOT_IDX_W-1:0] scan_idx;
  logic [SLOT_IDX_W-1:0] rd_idx;
  logic                  rd_vld;
  logic [NUM_SLOTS-1:0]  mask;
  logic [NUM_SLOTS-1:0]  low_bit;
  logic [SLOT_IDX_W-1:0] low_idx;
  logic [SLOT_IDX_W-1:0] wr_idx;
  logic                  slot_ok;
  logic                  is_tick;
  logic                  is_reg;
  logic                  is_unreg;
  logic                  is_kick;
  logic [TICK_W-1:0]     since_scan;
  logic [TICK_W-1:0]     elapsed;
  logic                  overdue;

  // Decode the request word
  assign slot_ok  = {1'b0, slot} < (SLOT_W + 1)'(NUM_SLOTS);
  assign wr_idx   = slot[SLOT_IDX_W-1:0];
  assign is_tick  = operation == OP_TICK;
  assign is_reg   = operation == OP_REGISTER;
  assign is_unreg = operation == OP_UNREGISTER;
  assign is_kick  = operation == OP_KICK;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_interval <= SCAN_INTERVAL_RST;
    end else if (cfg_wr && cfg_sel == REG_SCAN_INTERVAL) begin
      scan_interval <= cfg_wdata;
    end
  end

  assign cfg_rdata = (cfg_sel == REG_SCAN_INTERVAL) ? scan_interval : '0;

  // Advance the time base and stamp scans
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now       <= '0;
      last_scan_time <= '0;
    end else begin
      if (cmd.accept && is_tick) begin
        time_now <= time_now + TICK_W'(1);
      end
      if (cmd.scan_start) begin
        last_scan_time <= time_now;
      end
    end
  end

  assign since_scan   = time_now - last_scan_time;
  assign sts.scan_due = since_scan >= scan_interval;

  // Arm and disarm slots
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
    end else if (cmd.accept && slot_ok) begin
      if (is_reg) begin
        armed[wr_idx] <= 1'b1;
      end else if (is_unreg) begin
        armed[wr_idx] <= 1'b0;
      end
    end
  end

  // Slot tables: one write port, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (cmd.accept && slot_ok && (is_reg || is_kick)) begin
      kick_mem[wr_idx] <= time_now;
    end
    if (cmd.accept && slot_ok && is_reg) begin
      delay_mem[wr_idx] <= delay_limit;
    end
    if (cmd.scan_rd) begin
      kick_q  <= kick_mem[scan_idx];
      delay_q <= delay_mem[scan_idx];
      rd_idx  <= scan_idx;
    end
  end

  // Step the scan index and track the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_rd;
      if (cmd.scan_start) begin
        scan_idx <= '0;
      end else if (cmd.scan_rd) begin
        scan_idx <= scan_idx + SLOT_IDX_W'(1);
      end
    end
  end

  assign sts.scan_last = scan_idx == SLOT_IDX_W'(NUM_SLOTS - 1);

  // Compare elapsed time against the permitted delay
  assign elapsed = time_now - kick_q;
  assign overdue = armed[rd_idx] && (elapsed >= delay_q);

  // Collect overdue slots, then drop them lowest first as they are reported
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cmd.scan_start) begin
      mask <= '0;
    end else if (rd_vld) begin
      mask[rd_idx] <= overdue;
    end else if (cmd.pop) begin
      mask <= mask & ~low_bit;
    end
  end

  // Find the lowest pending slot
  always_comb begin
    low_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        low_idx = SLOT_IDX_W'(i);
      end
    end
  end

  assign low_bit         = mask & (~mask + NUM_SLOTS'(1));
  assign sts.mask_any    = |mask;
  assign sts.mask_single = sts.mask_any && ((mask & (mask - NUM_SLOTS'(1))) == '0);
  assign expired_slot    = SLOT_W'(low_idx);
  assign last            = sts.mask_single;

  // A table read result follows exactly one read command
  a_rd_follows_cmd: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(cmd.scan_rd))
    else $error("scan compare without a table read");

  // A pop always removes exactly one pending slot
  a_pop_one: assert property (@(posedge clk) disable iff (rst)
    cmd.pop && !cmd.scan_start && !rd_vld |=> $countones(mask) == $countones($past(mask)) - 1)
    else $error("pop did not remove one overdue slot");

  // Scan restarts only from a cleared index after stamping
  a_scan_rewind: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |=> scan_idx == '0 && mask == '0)
    else $error("scan did not rewind");

endmodule

// ----- design/mcw_ctrl.sv -----
// Watchdog controller: sequences request handling, scans and result reporting.
module mcw_ctrl import mcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_op,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  mcw_sts_t   sts,
  output mcw_cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_EMIT  = 5'b10000
  } mcw_state_t;

  mcw_state_t state;
  mcw_state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (req_op == OP_TICK) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts.scan_due) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.mask_any) begin
          state_next = ST_IDLE;
        end else begin
          rsp_valid = 1'b1;
          if (rsp_ready) begin
            cmd.pop = 1'b1;
            if (sts.mask_single) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Results only go out once the scan has fully settled
  a_emit_after_flush: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && $past(state) != ST_EMIT |-> $past(state) == ST_FLUSH)
    else $error("reporting entered without a completed scan");

  // A marked final result closes the run
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && sts.mask_single |=> state == ST_IDLE)
    else $error("run continued after the final result");

  // No new request is taken while a scan or report is under way
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !rsp_valid && !cmd.scan_rd)
    else $error("request taken while busy");

endmodule
